// ===== hdl/salc_pkg.sv =====
// salc_pkg: shared constants, codes and types for the set-associative LRU tracker.
// No dependencies.
`timescale 1ns / 1ps

package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_BITS    = 48;

  localparam int SET_COUNT  = 1 << MAX_SET_BITS;
  localparam int SET_W      = MAX_SET_BITS;
  localparam int WAY_IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int AGE_W      = WAY_IDX_W;
  localparam int RANK_W     = WAY_CNT_W;
  localparam int CNT_W      = 32;

  localparam int SB_W       = 3;
  localparam int BB_W       = 4;
  localparam int WAYS_W     = 4;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int SHIFT_W    = 5;
  localparam int REQ_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

  localparam logic [SB_W-1:0]   SET_BITS_RST   = 3'd1;
  localparam logic [BB_W-1:0]   BLOCK_BITS_RST = 4'd4;
  localparam logic [WAYS_W-1:0] WAYS_RST       = 4'd1;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                valid;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]     age;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic hit;
    logic evict;
    row_t new_row;
  } lk_res_t;

endpackage

// ===== hdl/salc_row_ram.sv =====
// salc_row_ram: single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module salc_row_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/salc_lookup.sv =====
// salc_lookup: tag compare, victim choice and LRU rank update for one set row.
// Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_lookup (
  input  salc_pkg::row_t                       row_i,
  input  logic [salc_pkg::ADDR_BITS-1:0]       tag_i,
  input  logic [salc_pkg::WAY_CNT_W-1:0]       nw_i,
  output salc_pkg::lk_res_t                    res_o
);
  import salc_pkg::*;

  logic [MAX_WAYS-1:0]  used;
  logic [MAX_WAYS-1:0]  match;
  logic [MAX_WAYS-1:0]  empty;
  logic [WAY_IDX_W-1:0] hit_way;
  logic [WAY_IDX_W-1:0] free_way;
  logic [WAY_IDX_W-1:0] old_way;
  logic [WAY_IDX_W-1:0] sel_way;
  logic [RANK_W-1:0]    old_rank;
  logic                 hit;
  logic                 has_free;
  row_t                 nrow;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      used[w]  = WAY_CNT_W'(w) < nw_i;
      match[w] = used[w] && row_i.valid[w] && (row_i.tag[w] == tag_i);
      empty[w] = used[w] && !row_i.valid[w];
    end

    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_IDX_W'(w);
      end
      if (empty[w]) begin
        free_way = WAY_IDX_W'(w);
      end
    end

    // oldest valid way, lowest index on a tie
    old_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (used[w] && row_i.valid[w] &&
          ((row_i.age[w] > row_i.age[old_way]) || !row_i.valid[old_way])) begin
        old_way = WAY_IDX_W'(w);
      end
    end

    hit      = |match;
    has_free = |empty;

    if (hit) begin
      sel_way  = hit_way;
      old_rank = RANK_W'(row_i.age[hit_way]);
    end else if (has_free) begin
      sel_way  = free_way;
      old_rank = RANK_W'(MAX_WAYS);
    end else begin
      sel_way  = old_way;
      old_rank = RANK_W'(row_i.age[old_way]);
    end

    nrow = row_i;
    if (!hit) begin
      nrow.valid[sel_way] = 1'b1;
      nrow.tag[sel_way]   = tag_i;
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (used[k] && (WAY_IDX_W'(k) != sel_way) && row_i.valid[k] &&
          (RANK_W'(row_i.age[k]) < old_rank) &&
          (row_i.age[k] != AGE_W'(MAX_WAYS - 1))) begin
        nrow.age[k] = row_i.age[k] + AGE_W'(1);
      end
    end
    nrow.age[sel_way] = '0;

    res_o.hit     = hit;
    res_o.evict   = !hit && !has_free;
    res_o.new_row = nrow;
  end

endmodule

// ===== hdl/set_assoc_lru_cache_tracker.sv =====
// Set-associative LRU cache tag tracker: one row per set in a synchronous RAM.
// The result is registered when the lookup state steps, after the registered RAM read; a stalled result stalls it.
// A new request is taken only in the idle state; a modify makes a second access on the forwarded row.
// The RAM read and the read-modify-write lookup of one set row bound the rate.
// Reset (sync, active low): 64 row-valid flags cleared, no clearing pass; counters zero.
// Any write to a listed register also clears the row-valid flags.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [salc_pkg::REQ_W-1:0]          in_req_type,
  input  logic [salc_pkg::ADDR_BITS-1:0]      in_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic                                out_evicted,
  output logic [salc_pkg::CNT_W-1:0]          out_hit_total,
  output logic [salc_pkg::CNT_W-1:0]          out_miss_total,
  output logic [salc_pkg::CNT_W-1:0]          out_eviction_total,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]          cfg_wdata
);
  import salc_pkg::*;

  state_t                 state_r, state_nxt;
  logic [SB_W-1:0]        set_bits_r;
  logic [BB_W-1:0]        block_bits_r;
  logic [WAYS_W-1:0]      ways_r;
  logic                   cfg_clear;

  logic [SET_COUNT-1:0]   row_ok_r;
  logic [SET_W-1:0]       set_r;
  logic [ADDR_BITS-1:0]   tag_r;
  logic                   mod_r;
  logic                   second_r, second_nxt;
  logic                   use_fwd_r, use_fwd_nxt;
  row_t                   fwd_row_r;

  logic [CNT_W-1:0]       hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_evicted_r, out_last_r;

  logic [SB_W-1:0]        sb_eff;
  logic [WAY_CNT_W-1:0]   nw_eff;
  logic [SHIFT_W-1:0]     tag_shift;
  logic [ADDR_BITS-1:0]   addr_shifted;
  logic [SET_W:0]         set_mask_w;
  logic [SET_W-1:0]       set_nxt;
  logic [ADDR_BITS-1:0]   tag_nxt;

  logic                   in_fire;
  logic                   step;
  logic                   last_access;
  logic [ROW_W-1:0]       rd_data;
  row_t                   ram_row;
  row_t                   cur_row;
  lk_res_t                lk;

  // configuration
  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS, CFG_BLOCK_BITS, CFG_WAYS: cfg_clear = 1'b1;
        default:                                cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SB_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BB_W-1:0];
        CFG_WAYS:       ways_r       <= cfg_wdata[WAYS_W-1:0];
        default:        ;
      endcase
    end
  end

  // address split
  always_comb begin
    sb_eff       = (set_bits_r > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_r == '0) begin
      nw_eff = WAY_CNT_W'(1);
    end else if (ways_r > WAYS_W'(MAX_WAYS)) begin
      nw_eff = WAY_CNT_W'(MAX_WAYS);
    end else begin
      nw_eff = WAY_CNT_W'(ways_r);
    end
    tag_shift    = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits_r);
    addr_shifted = in_address >> block_bits_r;
    set_mask_w   = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
    set_nxt      = addr_shifted[SET_W-1:0] & set_mask_w[SET_W-1:0];
    tag_nxt      = in_address >> tag_shift;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign step     = (state_r == ST_LOOK) && (!out_valid_r || out_ready);
  assign last_access = !(mod_r && !second_r);

  salc_row_ram #(
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (step),
    .wr_addr (set_r),
    .wr_data (lk.new_row),
    .rd_en   (in_fire),
    .rd_addr (set_nxt),
    .rd_data (rd_data)
  );

  always_comb begin
    ram_row = row_t'(rd_data);
    if (!row_ok_r[set_r]) begin
      ram_row.valid = '0;
      ram_row.age   = '0;
    end
    cur_row = use_fwd_r ? fwd_row_r : ram_row;
  end

  salc_lookup u_lookup (
    .row_i (cur_row),
    .tag_i (tag_r),
    .nw_i  (nw_eff),
    .res_o (lk)
  );

  // control
  always_comb begin
    state_nxt     = state_r;
    second_nxt    = second_r;
    use_fwd_nxt   = use_fwd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt   = ST_LOOK;
          second_nxt  = 1'b0;
          use_fwd_nxt = 1'b0;
        end
      end
      ST_LOOK: begin
        if (step) begin
          out_valid_nxt = 1'b1;
          if (last_access) begin
            state_nxt   = ST_IDLE;
            use_fwd_nxt = 1'b0;
          end else begin
            second_nxt  = 1'b1;
            use_fwd_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      second_r    <= 1'b0;
      use_fwd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      use_fwd_r   <= use_fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
    end else if (cfg_clear) begin
      row_ok_r <= '0;
    end else if (step) begin
      row_ok_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (step) begin
      if (lk.hit) begin
        hit_cnt_r <= hit_cnt_r + CNT_W'(hit_cnt_r != '1);
      end else begin
        miss_cnt_r <= miss_cnt_r + CNT_W'(miss_cnt_r != '1);
      end
      if (lk.evict) begin
        evict_cnt_r <= evict_cnt_r + CNT_W'(evict_cnt_r != '1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r <= set_nxt;
      tag_r <= tag_nxt;
      mod_r <= (in_req_type == REQ_MODIFY);
    end
    if (step) begin
      fwd_row_r     <= lk.new_row;
      out_hit_r     <= lk.hit;
      out_evicted_r <= lk.evict;
      out_last_r    <= last_access;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_evicted        = out_evicted_r;
  assign out_last           = out_last_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

endmodule

// ===== hdl/salc_checker.sv =====
// salc_checker: port-level assertions for the LRU tracker, bound to the top level.
// Depends on salc_pkg and set_assoc_lru_cache_tracker.
`timescale 1ns / 1ps

module salc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_hit,
  input logic                       out_evicted,
  input logic [salc_pkg::CNT_W-1:0] out_hit_total,
  input logic [salc_pkg::CNT_W-1:0] out_miss_total,
  input logic [salc_pkg::CNT_W-1:0] out_eviction_total,
  input logic                       out_last
);
  import salc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while lookup in flight");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |->
      (!out_hit && (out_miss_total != '0) && (out_eviction_total != '0)))
    else $error("eviction reported on a hit or with zero totals");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_hit_total) && $stable(out_last)))
    else $error("stalled result beat changed");

endmodule

bind set_assoc_lru_cache_tracker salc_checker u_salc_checker (.*);

// ===== tb/salc_access_checker.sv =====
// salc_access_checker: watches the request, result and register ports of the LRU tracker,
// predicts every result beat from its own tag/rank model and compares it field by field.
// Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_access_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [salc_pkg::REQ_W-1:0]     in_req_type,
  input  logic [salc_pkg::ADDR_BITS-1:0] in_address,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_hit,
  input  logic                           out_evicted,
  input  logic [salc_pkg::CNT_W-1:0]     out_hit_total,
  input  logic [salc_pkg::CNT_W-1:0]     out_miss_total,
  input  logic [salc_pkg::CNT_W-1:0]     out_eviction_total,
  input  logic                           out_last,
  input  logic                           cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             outstanding,
  output int                             beats_checked
);
  import salc_pkg::*;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
    logic             last;
  } access_result_t;

  access_result_t       expected_beats[$];

  logic                 line_ok    [SET_COUNT][MAX_WAYS];
  logic [ADDR_BITS-1:0] line_tag_q [SET_COUNT][MAX_WAYS];
  logic [AGE_W-1:0]     line_rank  [SET_COUNT][MAX_WAYS];
  logic [CNT_W-1:0]     hits, misses, evictions;
  logic [SB_W-1:0]      geo_set_bits;
  logic [BB_W-1:0]      geo_block_bits;
  logic [WAYS_W-1:0]    geo_ways;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0h want %0h", beats_checked, name, got, want));
  endtask

  task automatic flush_lines();
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        line_ok[s][w]    = 1'b0;
        line_tag_q[s][w] = '0;
        line_rank[s][w]  = '0;
      end
    end
  endtask

  task automatic cache_access(input logic [ADDR_BITS-1:0] addr, input logic is_last);
    int                   sb, nw, set_idx, w, hit_way, free_way, lru_way, old_rank;
    logic [ADDR_BITS-1:0] tag, one_a;
    logic                 hit, evict;
    access_result_t       r;
    one_a    = ADDR_BITS'(1);
    sb       = (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : geo_set_bits;
    nw       = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : geo_ways);
    set_idx  = int'((addr >> geo_block_bits) & ((one_a << sb) - one_a));
    tag      = addr >> (sb + geo_block_bits);
    hit      = 1'b0;
    evict    = 1'b0;
    hit_way  = 0;
    free_way = -1;
    lru_way  = 0;
    for (w = 0; w < nw; w++) begin
      if (line_ok[set_idx][w]) begin
        if (!hit && line_tag_q[set_idx][w] == tag) begin
          hit     = 1'b1;
          hit_way = w;
        end
        if (line_rank[set_idx][w] > line_rank[set_idx][lru_way] || !line_ok[set_idx][lru_way])
          lru_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (hit) begin
      w        = hit_way;
      old_rank = line_rank[set_idx][w];
      if (hits != '1) hits++;
    end else begin
      if (free_way >= 0) begin
        w        = free_way;
        old_rank = MAX_WAYS;
      end else begin
        w        = lru_way;
        old_rank = line_rank[set_idx][w];
        evict    = 1'b1;
        if (evictions != '1) evictions++;
      end
      if (misses != '1) misses++;
      line_ok[set_idx][w]    = 1'b1;
      line_tag_q[set_idx][w] = tag;
    end
    // age every younger valid way by one, capped at the oldest rank
    for (int k = 0; k < nw; k++) begin
      if (k != w && line_ok[set_idx][k] && line_rank[set_idx][k] < old_rank &&
          line_rank[set_idx][k] < MAX_WAYS - 1)
        line_rank[set_idx][k]++;
    end
    line_rank[set_idx][w] = '0;
    r.hit            = hit;
    r.evicted        = evict;
    r.hit_total      = hits;
    r.miss_total     = misses;
    r.eviction_total = evictions;
    r.last           = is_last;
    expected_beats.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    access_result_t want;
    if (!rst_n) begin
      flush_lines();
      hits           = '0;
      misses         = '0;
      evictions      = '0;
      geo_set_bits   = SET_BITS_RST;
      geo_block_bits = BLOCK_BITS_RST;
      geo_ways       = WAYS_RST;
      expected_beats.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = expected_beats.pop_front();
          check_field("hit", out_hit, want.hit);
          check_field("evicted", out_evicted, want.evicted);
          check_field("hit_total", out_hit_total, want.hit_total);
          check_field("miss_total", out_miss_total, want.miss_total);
          check_field("eviction_total", out_eviction_total, want.eviction_total);
          check_field("last", out_last, want.last);
          beats_checked++;
        end
      end
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_SET_BITS: begin
            geo_set_bits = cfg_wdata[SB_W-1:0];
            flush_lines();
          end
          CFG_BLOCK_BITS: begin
            geo_block_bits = cfg_wdata[BB_W-1:0];
            flush_lines();
          end
          CFG_WAYS: begin
            geo_ways = cfg_wdata[WAYS_W-1:0];
            flush_lines();
          end
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        cache_access(in_address, in_req_type != REQ_MODIFY);
        if (in_req_type == REQ_MODIFY) cache_access(in_address, 1'b1);
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

// ===== tb/tb_set_assoc_lru_cache_tracker.sv =====
// tb_set_assoc_lru_cache_tracker: clock, reset, request and register stimulus, result-side
// back-pressure and the verdict. Checking lives in salc_access_checker; needs salc_pkg.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_tracker;
  import salc_pkg::*;

  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid, in_ready;
  logic [REQ_W-1:0]     in_req_type;
  logic [ADDR_BITS-1:0] in_address;
  logic                 out_valid, out_ready;
  logic                 out_hit, out_evicted, out_last;
  logic [CNT_W-1:0]     out_hit_total, out_miss_total, out_eviction_total;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count, outstanding, beats_checked;
  int requests_sent = 0;
  int geometries    = 1;

  logic                 hold_off_req  = 1'b0;
  logic                 hold_off_done = 1'b0;
  logic [SB_W-1:0]      cur_set_bits;
  logic [BB_W-1:0]      cur_block_bits;
  logic [WAYS_W-1:0]    cur_ways;
  logic [ADDR_BITS-1:0] tag_pool [16];
  int                   set_pool [3];

  always #5 clk = ~clk;

  set_assoc_lru_cache_tracker uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  salc_access_checker access_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .beats_checked      (beats_checked)
  );

  // called on a rising-edge step; returns on the step at which the beat is taken
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_BITS-1:0] addr);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_address  <= addr;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_geometry(input logic [SB_W-1:0] sb, input logic [BB_W-1:0] bb,
                                input logic [WAYS_W-1:0] nw);
    logic [63:0] raw;
    wait_for_drain();
    repeat (3) @(posedge clk);
    write_reg(CFG_SET_BITS, CFG_W'(sb));
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_WAYS, nw);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_set_bits   = sb;
    cur_block_bits = bb;
    cur_ways       = nw;
    geometries++;
    for (int i = 0; i < 16; i++) begin
      raw         = {$urandom, $urandom};
      tag_pool[i] = raw[ADDR_BITS-1:0];
    end
    for (int i = 0; i < 3; i++) set_pool[i] = $urandom_range(0, SET_COUNT - 1);
  endtask

  // mostly a small pool of tags in a few sets so hits and LRU evictions are frequent
  function automatic logic [ADDR_BITS-1:0] pick_address();
    int                   sb, nw, set_idx;
    logic [63:0]          raw;
    logic [ADDR_BITS-1:0] tag, set_f, offset, one_a;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return raw[ADDR_BITS-1:0];
    one_a   = ADDR_BITS'(1);
    sb      = (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cur_set_bits;
    nw      = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
    tag     = tag_pool[$urandom_range(0, nw + 2)];
    set_idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SET_COUNT - 1)
                                          : set_pool[$urandom_range(0, 2)];
    set_f   = ADDR_BITS'(set_idx) & ((one_a << sb) - one_a);
    offset  = raw[ADDR_BITS-1:0] & ((one_a << cur_block_bits) - one_a);
    return (tag << (sb + cur_block_bits)) | (set_f << cur_block_bits) | offset;
  endfunction

  function automatic logic [REQ_W-1:0] pick_req();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return REQ_LOAD;
    if (r < 13) return REQ_STORE;
    if (r < 18) return REQ_MODIFY;
    return REQ_UNKNOWN;
  endfunction

  // result side: runs of differing stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode, run_len, k;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(16, 160);
      for (k = 0; k < run_len; k++) begin
        if (hold_off_req && !hold_off_done) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_off_done = 1'b1;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (k % 5 != 4);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int p, n, gap, burst_left, drain_cycles;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_LOAD;
    in_address  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_SET_BITS;
    cfg_wdata   <= '0;
    cur_set_bits   = SET_BITS_RST;
    cur_block_bits = BLOCK_BITS_RST;
    cur_ways       = WAYS_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: two sets, 16-byte blocks, direct mapped
    send_request(REQ_LOAD, 48'h0);
    send_request(REQ_LOAD, 48'h0);
    send_request(REQ_STORE, 48'hF);
    send_request(REQ_STORE, 48'h10);
    send_request(REQ_MODIFY, 48'h20);
    send_request(REQ_UNKNOWN, 48'hFFFF_FFFF_FFFF);
    send_request(REQ_LOAD, 48'h0);
    // a write to the spare index must leave the lines alone
    wait_for_drain();
    repeat (3) @(posedge clk);
    write_reg(CFG_UNUSED, 4'hF);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_request(REQ_LOAD, 48'h0);

    // set bits above the maximum, widest offset, zero ways
    write_geometry(3'd7, 4'd15, 4'd0);
    send_request(REQ_LOAD, 48'hFFFF_FFFF_FFFF);
    send_request(REQ_STORE, 48'hFFFF_FFFF_8000);
    send_request(REQ_MODIFY, 48'h0);
    send_request(REQ_LOAD, 48'h20_0000);

    // one set, no offset, ways above the maximum: walk the LRU order
    write_geometry(3'd0, 4'd0, 4'd15);
    for (n = 0; n <= MAX_WAYS; n++) send_request(REQ_LOAD, ADDR_BITS'(n));
    send_request(REQ_LOAD, 48'h0);
    send_request(REQ_MODIFY, 48'h1);

    burst_left = 0;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_geometry(3'd1, 4'd4, 4'd2);
        1:       write_geometry(3'd6, 4'd12, 4'd8);
        2:       write_geometry(3'd2, 4'd1, 4'd4);
        3:       write_geometry(3'd3, 4'd6, 4'd3);
        4:       write_geometry(3'd6, 4'd1, 4'd9);
        5:       write_geometry(3'd7, 4'd2, 4'd15);
        6:       write_geometry(3'd0, 4'd3, 4'd8);
        default: write_geometry(3'd4, 4'd12, 4'd0);
      endcase
      if (p == 1) hold_off_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) wait_for_drain();
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap = ((hold_off_req && !hold_off_done) || p % 3 == 2) ? 0 : $urandom_range(0, 8);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_request(pick_req(), pick_address());
        burst_left--;
      end
    end

    in_valid <= 1'b0;
    drain_cycles = 0;
    do begin
      @(negedge clk);
      drain_cycles++;
    end while (outstanding != 0 && drain_cycles < DRAIN_LIMIT);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (loads, stores, modifies, unknown codes) over %0d geometries.",
             requests_sent, geometries);
    $display("Compared %0d result beats; %0d mismatches, %0d still pending.",
             beats_checked, fail_count, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_set_assoc_lru_cache_tracker: PASS");
    end else begin
      $display("tb_set_assoc_lru_cache_tracker: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb_set_assoc_lru_cache_tracker: FAIL");
    $finish;
  end

endmodule
